// ===== sv/dqp_pkg.sv =====
`default_nettype none

package dqp_pkg;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] MAX_DIGITS = 2'd3;
  localparam logic [1:0] LAST_FIELD = 2'd3;

  // Parser state carried from one character to the next
  typedef struct packed {
    logic [1:0]  field_index;
    logic [1:0]  digit_count;
    logic [7:0]  field_value;
    logic [23:0] done_fields;
    logic        skipping;
  } parse_state_t;

  // Result of one parse step
  typedef struct packed {
    logic        emit;
    logic        ok;
    logic [31:0] address;
  } parse_result_t;

endpackage

`default_nettype wire

// ===== sv/dqp_step.sv =====
`default_nettype none

module dqp_step (
  input  wire logic [7:0]            ch,
  input  wire dqp_pkg::parse_state_t st,
  output dqp_pkg::parse_state_t      st_nxt,
  output dqp_pkg::parse_result_t     res
);
  import dqp_pkg::*;

  logic       line_end;
  logic       is_digit;
  logic       in_early;
  logic [7:0] digit_val;
  logic [7:0] acc_val;

  assign line_end  = (ch == CH_NUL) || (ch == CH_NL);
  assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign in_early  = (st.field_index != LAST_FIELD);
  assign digit_val = ch - CH_ZERO;
  // value * 10 + digit, modulo 256
  assign acc_val   = {st.field_value[4:0], 3'b000} + {st.field_value[6:0], 1'b0} + digit_val;

  // Decide next state and result for one character
  always_comb begin
    st_nxt      = st;
    res.emit    = 1'b0;
    res.ok      = 1'b0;
    res.address = '0;
    if (st.skipping) begin
      // drop characters until a line end rearms the parser
      if (line_end) begin
        st_nxt = '0;
      end
    end else if (in_early && (ch == CH_DOT)) begin
      st_nxt.done_fields = {st.done_fields[15:0], st.field_value};
      st_nxt.field_index = st.field_index + 2'd1;
      st_nxt.digit_count = '0;
      st_nxt.field_value = '0;
    end else if (in_early && line_end) begin
      // end of text before the last field
      res.emit        = 1'b1;
      st_nxt          = '0;
      st_nxt.skipping = 1'b0;
    end else if (!in_early && ((ch == CH_SPACE) || line_end)) begin
      res.emit        = 1'b1;
      res.ok          = 1'b1;
      res.address     = {st.done_fields, st.field_value};
      st_nxt          = '0;
      st_nxt.skipping = !line_end;
    end else if ((st.digit_count == MAX_DIGITS) || !is_digit) begin
      res.emit        = 1'b1;
      st_nxt          = '0;
      st_nxt.skipping = !line_end;
    end else begin
      st_nxt.digit_count = st.digit_count + 2'd1;
      st_nxt.field_value = acc_val;
    end
  end

endmodule

`default_nettype wire

// ===== sv/dotted_quad_ipv4_parser_core.sv =====
// Channel   | Ports                          | Direction
// ----------+--------------------------------+----------
// input     | in_valid, in_ready, in_ch      | in
// result    | out_valid, out_ready, out_ok,  | out
//           | out_address                    |
//
// One character per cycle unless a result stalls: each character is held in
// the input register, where the parse step updates the state and loads the
// result register, which gets at most one result per transaction.
// Reset (synchronous, rst_n low) clears the parser state and both valid bits.
// A stalled result holds the input register; in_ready stays high while the
// input register is empty or is advancing in the same cycle.
`default_nettype none

module dotted_quad_ipv4_parser_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_ch,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_ok,
  output logic [31:0]      out_address
);
  import dqp_pkg::*;

  logic          in_valid_r;
  logic [7:0]    in_ch_r;
  parse_state_t  st_r;
  parse_state_t  st_nxt;
  parse_result_t res;
  logic          out_ok_r;
  logic [31:0]   out_address_r;
  logic          out_valid_r;
  logic          advance;

  dqp_step u_step (
    .ch     (in_ch_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // Step the held character when the result register can take a result
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_ch_r <= in_ch;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res.emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      out_ok_r      <= res.ok;
      out_address_r <= res.address;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_ok      = out_ok_r;
  assign out_address = out_address_r;

endmodule

`default_nettype wire
